// ----- rtl/core/lsbe_pkg.sv -----
`default_nettype none
package lsbe_pkg;

	// Default sizing, handed down from the top level
	localparam int MAX_LEDS_DEF    = 256;
	localparam int RESET_SLOTS_DEF = 50;

	// Frame layout: three colours per LED, eight bits per colour
	localparam int COLOURS_PER_LED = 3;
	localparam int TOP_BIT         = 7;
	localparam int BITS_PER_LED    = COLOURS_PER_LED * (TOP_BIT + 1);
	localparam int BIT_W           = $clog2(BITS_PER_LED);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration register indexes
	localparam logic [1:0] REG_STRIP_LEN = 2'd0;
	localparam logic [1:0] REG_ONE_DUTY  = 2'd1;
	localparam logic [1:0] REG_ZERO_DUTY = 2'd2;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	// Classified command kinds
	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_START,
		CMD_TICK,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  index;
		logic [23:0] colour;  // green 23:16, red 15:8, blue 7:0
	} cmd_t;

	typedef struct packed {
		logic [8:0]  strip_len;
		logic [15:0] one_duty;
		logic [15:0] zero_duty;
	} cfg_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef struct packed {
		logic        busy_now;
		logic        accepted;
		logic        last_slot;
		logic [15:0] duty;
		logic        slot_valid;
	} res_t;

	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_READ
	} back_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/led_strip_bit_slot_encoder.sv -----
// A pixel write, start or unused code passes the command queue and the output register;
//   a slot tick also passes the BS_READ state for the store read, holding the next command.
// Throughput: one write or start per cycle while results are taken.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes every colour store
//   entry, during which no item is accepted (register writes are taken).
`default_nettype none
module led_strip_bit_slot_encoder #(
	parameter int MAX_LEDS    = lsbe_pkg::MAX_LEDS_DEF,
	parameter int RESET_SLOTS = lsbe_pkg::RESET_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // led_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // slot_valid[0], duty[16:1], accepted[17],
	                                    // busy_now[18], zero[23:19]
	output logic             m_tlast,   // last_slot
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	lsbe_pkg::cfg_t         cfg_q;
	lsbe_pkg::cmd_t         push_cmd, q_cmd;
	lsbe_pkg::back_status_t status;
	lsbe_pkg::res_t         res;
	logic                   push, q_full, q_valid, pop;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register writes; LED count saturates at the store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				lsbe_pkg::REG_STRIP_LEN:
					if ({23'b0, pwdata[8:0]} > 32'(MAX_LEDS))
						cfg_q.strip_len <= 9'(MAX_LEDS);
					else
						cfg_q.strip_len <= pwdata[8:0];
				lsbe_pkg::REG_ONE_DUTY:  cfg_q.one_duty  <= pwdata[15:0];
				lsbe_pkg::REG_ZERO_DUTY: cfg_q.zero_duty <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (paddr[3:2])
			lsbe_pkg::REG_STRIP_LEN: prdata = {23'b0, cfg_q.strip_len};
			lsbe_pkg::REG_ONE_DUTY:  prdata = {16'b0, cfg_q.one_duty};
			lsbe_pkg::REG_ZERO_DUTY: prdata = {16'b0, cfg_q.zero_duty};
			default:                 prdata = '0;
		endcase
	end

	lsbe_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.status   (status),
		.push     (push),
		.cmd      (push_cmd)
	);

	lsbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd)
	);

	lsbe_back #(
		.MAX_LEDS    (MAX_LEDS),
		.RESET_SLOTS (RESET_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {5'b0, res.busy_now, res.accepted, res.duty, res.slot_valid};
	assign m_tlast = res.last_slot;

endmodule
`default_nettype wire

// ----- rtl/core/lsbe_front.sv -----
`default_nettype none
module lsbe_front (
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,   // led_index, red, green, blue
	input  wire logic [1:0]            s_tuser,   // operation
	input  wire logic                  q_full,
	input  wire lsbe_pkg::back_status_t status,
	output logic                       push,
	output lsbe_pkg::cmd_t             cmd
);

	// Hold off while the queue is full or the store is being cleared
	assign s_tready = !q_full && !status.clearing;
	assign push     = s_tvalid && s_tready;

	// Classify the operation and pack the colour as green-red-blue
	always_comb begin
		case (s_tuser)
			lsbe_pkg::OP_WRITE: cmd.kind = lsbe_pkg::CMD_WRITE;
			lsbe_pkg::OP_START: cmd.kind = lsbe_pkg::CMD_START;
			lsbe_pkg::OP_TICK:  cmd.kind = lsbe_pkg::CMD_TICK;
			default:            cmd.kind = lsbe_pkg::CMD_NOP;
		endcase
		cmd.index  = s_tdata[7:0];
		cmd.colour = {s_tdata[23:16], s_tdata[15:8], s_tdata[31:24]};
	end

endmodule
`default_nettype wire

// ----- rtl/core/lsbe_queue.sv -----
`default_nettype none
module lsbe_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lsbe_pkg::cmd_t wr_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                rd_valid,
	output lsbe_pkg::cmd_t      rd_cmd
);

	lsbe_pkg::cmd_t entry_q [lsbe_pkg::QUEUE_DEPTH];
	logic [lsbe_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [lsbe_pkg::QPTR_W:0]   count_q;

	assign full     = (count_q == (lsbe_pkg::QPTR_W+1)'(lsbe_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_cmd;
	end

endmodule
`default_nettype wire

// ----- rtl/core/lsbe_back.sv -----
`default_nettype none
module lsbe_back #(
	parameter int MAX_LEDS    = lsbe_pkg::MAX_LEDS_DEF,
	parameter int RESET_SLOTS = lsbe_pkg::RESET_SLOTS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lsbe_pkg::cfg_t  cfg,
	input  wire logic            q_valid,
	input  wire lsbe_pkg::cmd_t  q_cmd,
	output logic                 pop,
	output lsbe_pkg::back_status_t status,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lsbe_pkg::res_t       out_res
);

	localparam int IW        = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int TOTAL_MAX = MAX_LEDS * lsbe_pkg::BITS_PER_LED + RESET_SLOTS;
	localparam int PW        = $clog2(TOTAL_MAX);
	localparam int LW        = $clog2(TOTAL_MAX / lsbe_pkg::BITS_PER_LED + 1);
	localparam int CW        = (PW + 1 > 14) ? PW + 1 : 14;
	localparam int BW        = lsbe_pkg::BIT_W;

	lsbe_pkg::back_state_t state_q, state_nxt;

	logic          sending_q, sending_nxt;
	logic [PW-1:0] pos_q, pos_nxt;
	logic [LW-1:0] led_q, led_nxt;
	logic [BW-1:0] bit_q, bit_nxt;
	logic [IW-1:0] clr_q;
	logic          out_valid_q;
	lsbe_pkg::res_t out_q, res_nxt;
	logic          load_out;

	logic [23:0]   store [MAX_LEDS];
	logic [23:0]   rdata_q;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [23:0]   mem_wd;

	logic          slot_free;
	logic          clr_done;
	logic [CW-1:0] frame_total;
	logic [CW-1:0] pos_plus;
	logic          in_data;
	logic          data_bit;
	logic          idx_ok;

	assign slot_free = !out_valid_q || out_ready;
	assign clr_done  = (clr_q == IW'(MAX_LEDS - 1));
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign status.clearing = (state_q == lsbe_pkg::BS_CLEAR);

	// Frame length follows the current LED count: count * 24 + reset slots
	assign frame_total = CW'({cfg.strip_len, 4'b0000}) + CW'({cfg.strip_len, 3'b000})
		+ CW'(RESET_SLOTS);
	assign pos_plus = CW'(pos_q) + CW'(1);
	assign in_data  = ((LW + 9)'(cfg.strip_len) > (LW + 9)'(led_q));
	assign data_bit = rdata_q[BW'(lsbe_pkg::BITS_PER_LED - 1) - bit_q];
	assign idx_ok   = ({1'b0, q_cmd.index} < cfg.strip_len);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lsbe_pkg::BS_CLEAR:
				if (clr_done) state_nxt = lsbe_pkg::BS_IDLE;
			lsbe_pkg::BS_IDLE:
				if (q_valid && slot_free && q_cmd.kind == lsbe_pkg::CMD_TICK)
					state_nxt = lsbe_pkg::BS_READ;
			lsbe_pkg::BS_READ:
				if (slot_free) state_nxt = lsbe_pkg::BS_IDLE;
			default: state_nxt = lsbe_pkg::BS_CLEAR;
		endcase
	end

	// Command execution and result forming
	always_comb begin
		pop         = 1'b0;
		load_out    = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = IW'(q_cmd.index);
		mem_wd      = q_cmd.colour;
		sending_nxt = sending_q;
		pos_nxt     = pos_q;
		led_nxt     = led_q;
		bit_nxt     = bit_q;
		res_nxt     = '0;
		case (state_q)
			lsbe_pkg::BS_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			lsbe_pkg::BS_IDLE: begin
				if (q_valid && slot_free) begin
					pop = 1'b1;
					case (q_cmd.kind)
						lsbe_pkg::CMD_WRITE: begin
							load_out = 1'b1;
							if (!sending_q && idx_ok) begin
								mem_we           = 1'b1;
								res_nxt.accepted = 1'b1;
							end
						end
						lsbe_pkg::CMD_START: begin
							load_out = 1'b1;
							if (!sending_q) begin
								sending_nxt      = 1'b1;
								pos_nxt          = '0;
								led_nxt          = '0;
								bit_nxt          = '0;
								res_nxt.accepted = 1'b1;
							end
						end
						lsbe_pkg::CMD_TICK: ;  // result formed once the store word is in
						default: load_out = 1'b1;
					endcase
					res_nxt.busy_now = sending_nxt;
				end
			end
			lsbe_pkg::BS_READ: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (sending_q) begin
						res_nxt.slot_valid = 1'b1;
						if (in_data)
							res_nxt.duty = data_bit ? cfg.one_duty : cfg.zero_duty;
						if (pos_plus >= frame_total) begin
							res_nxt.last_slot = 1'b1;
							res_nxt.duty      = '0;
							sending_nxt       = 1'b0;
							pos_nxt           = '0;
							led_nxt           = '0;
							bit_nxt           = '0;
						end else begin
							pos_nxt = pos_q + 1'b1;
							if (bit_q == BW'(lsbe_pkg::BITS_PER_LED - 1)) begin
								bit_nxt = '0;
								led_nxt = led_q + 1'b1;
							end else begin
								bit_nxt = bit_q + 1'b1;
							end
						end
					end
					res_nxt.busy_now = sending_nxt;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsbe_pkg::BS_CLEAR;
			clr_q       <= '0;
			sending_q   <= 1'b0;
			pos_q       <= '0;
			led_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			sending_q <= sending_nxt;
			pos_q     <= pos_nxt;
			led_q     <= led_nxt;
			bit_q     <= bit_nxt;
			if (state_q == lsbe_pkg::BS_CLEAR) clr_q <= clr_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load_out) out_q <= res_nxt;
	end

	// Colour store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) store[mem_wa] <= mem_wd;
		rdata_q <= store[led_q[IW-1:0]];
	end

endmodule
`default_nettype wire

// ----- rtl/core/lsbe_checker.sv -----
`default_nettype none
module lsbe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tlast
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// The final slot is a slot at duty zero and ends the frame
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[0] && (m_tdata[16:1] == 16'd0) && !m_tdata[18])
		else $error("bad final slot");

	// A slot is never also an accepted write or start
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[17]))
		else $error("slot flagged accepted");

	// A slot before the last leaves the frame running
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] && !m_tlast |-> m_tdata[18])
		else $error("frame stopped before final slot");

endmodule

bind led_strip_bit_slot_encoder lsbe_checker u_lsbe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
